### rtl/uihb_pkg.sv
// types and constants shared by the udp/ipv4 header builder
// no dependencies

package uihb_pkg;

  localparam int HDR_LEN     = 42;
  localparam int IDX_W       = $clog2(HDR_LEN);
  localparam int SUM_W       = 20;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
  localparam logic [15:0] IP_LEN_ADD    = 16'd28;
  localparam logic [15:0] UDP_LEN_ADD   = 16'd8;

  localparam logic [47:0] LOCAL_MAC_RST = 48'h525400123456;
  localparam logic [47:0] PEER_MAC_RST  = 48'h52550A000202;
  localparam logic [31:0] LOCAL_IP_RST  = 32'h0A00020F;
  localparam logic [7:0]  HOP_LIMIT_RST = 8'd100;

  typedef enum logic [7:0] {
    CFG_LOCAL_MAC = 8'd0,
    CFG_PEER_MAC  = 8'd1,
    CFG_LOCAL_IP  = 8'd2,
    CFG_HOP_LIMIT = 8'd3
  } cfg_index_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [47:0] peer_mac;
    logic [31:0] own_ip;
    logic [7:0]  hop_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0]      udp_sport;
    logic [31:0]      dst_ip;
    logic [15:0]      dst_port;
    logic [15:0]      body_len;
    logic [SUM_W-1:0] hdr_sum;
    logic             reject;
  } req_t;

endpackage

### rtl/uihb_front.sv
// request front end: size check and ip header word sum
// depends on uihb_pkg

module uihb_front import uihb_pkg::*; #(
  parameter int MAX_FRAME = 4096
) (
  input  cfg_t        cfg,
  input  logic [15:0] udp_sport,
  input  logic [31:0] dst_ip,
  input  logic [15:0] dst_port,
  input  logic [15:0] body_len,
  output req_t        req
);

  logic [16:0] frame_len;
  logic [15:0] ip_total_len;

  always_comb begin
    frame_len    = {1'b0, body_len} + 17'(HDR_LEN);
    ip_total_len = body_len + IP_LEN_ADD;
    req.udp_sport = udp_sport;
    req.dst_ip    = dst_ip;
    req.dst_port  = dst_port;
    req.body_len  = body_len;
    req.reject    = frame_len > 17'(MAX_FRAME);
    // checksum field counts as zero; id and fragment words are zero
    req.hdr_sum = SUM_W'({IP_VER_IHL, 8'h00}) + SUM_W'(ip_total_len)
                + SUM_W'({cfg.hop_limit, IP_PROTO_UDP})
                + SUM_W'(cfg.own_ip[31:16]) + SUM_W'(cfg.own_ip[15:0])
                + SUM_W'(dst_ip[31:16]) + SUM_W'(dst_ip[15:0]);
  end

endmodule

### rtl/uihb_queue.sv
// short request queue between front end and byte sequencer
// depends on uihb_pkg

module uihb_queue import uihb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_data,
  output logic in_ready,
  input  logic pop,
  output logic out_valid,
  output req_t out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  req_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign in_ready  = count != (PTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/uihb_back.sv
// byte sequencer: folds the checksum and emits the header a byte per cycle
// while out_ready allows, one zero byte if rejected; depends on uihb_pkg

module uihb_back import uihb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  req_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_reject
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_LEN - 1);

  req_t             cur;
  logic [15:0]      csum;
  logic             active;
  logic [IDX_W-1:0] idx;

  logic             advance;
  logic             emit_last;
  logic [16:0]      fold1;
  logic [16:0]      fold2;
  logic [15:0]      csum_next;
  logic [7:0]       hdr [HDR_LEN];
  logic [15:0]      ip_len;
  logic [15:0]      udp_len;

  assign advance   = !out_valid || out_ready;
  assign emit_last = cur.reject || (idx == LAST_IDX);
  assign q_pop     = q_valid && (!active || (advance && emit_last));

  // end-around carry fold
  always_comb begin
    fold1     = {1'b0, q_data.hdr_sum[15:0]} + 17'(q_data.hdr_sum[SUM_W-1:16]);
    fold2     = {1'b0, fold1[15:0]} + 17'(fold1[16]);
    csum_next = ~fold2[15:0];
  end

  always_comb begin
    ip_len  = cur.body_len + IP_LEN_ADD;
    udp_len = cur.body_len + UDP_LEN_ADD;
    for (int i = 0; i < 6; i++) begin
      hdr[i]     = cfg.peer_mac[8*(5-i) +: 8];
      hdr[6 + i] = cfg.own_mac[8*(5-i) +: 8];
    end
    hdr[12] = ETH_TYPE_IPV4[15:8];
    hdr[13] = ETH_TYPE_IPV4[7:0];
    hdr[14] = IP_VER_IHL;
    hdr[15] = 8'h00;
    hdr[16] = ip_len[15:8];
    hdr[17] = ip_len[7:0];
    hdr[18] = 8'h00;
    hdr[19] = 8'h00;
    hdr[20] = 8'h00;
    hdr[21] = 8'h00;
    hdr[22] = cfg.hop_limit;
    hdr[23] = IP_PROTO_UDP;
    hdr[24] = csum[15:8];
    hdr[25] = csum[7:0];
    for (int i = 0; i < 4; i++) begin
      hdr[26 + i] = cfg.own_ip[8*(3-i) +: 8];
      hdr[30 + i] = cur.dst_ip[8*(3-i) +: 8];
    end
    hdr[34] = cur.udp_sport[15:8];
    hdr[35] = cur.udp_sport[7:0];
    hdr[36] = cur.dst_port[15:8];
    hdr[37] = cur.dst_port[7:0];
    hdr[38] = udp_len[15:8];
    hdr[39] = udp_len[7:0];
    hdr[40] = 8'h00;
    hdr[41] = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur  <= q_data;
      csum <= csum_next;
    end
    if (advance && active) begin
      out_byte   <= cur.reject ? 8'h00 : hdr[idx];
      out_last   <= emit_last;
      out_reject <= cur.reject;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= active;
      end
      if (q_pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (advance && active) begin
        if (emit_last) begin
          active <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

### rtl/udp_ipv4_header_builder.sv
// Takes one send request per s_tdata transaction and returns its 42-byte
// Ethernet/IPv4/UDP header on the m_ group, one byte per transaction, wire
// order, tlast on the final byte. A request whose frame (payload + 42 bytes)
// exceeds MAX_FRAME gives a single transaction with tdata 0, tlast 1 and
// tuser 1. Header bytes leave at one per cycle while m_tready is high;
// frames follow without a gap if the next request is queued. A two-entry
// request queue lets new requests be taken while a header is still going
// out, and feeds a current-request register ahead of the output register.
// Configuration writes belong in idle periods; cfg_ready is always high.
// depends on uihb_pkg, uihb_front, uihb_queue, uihb_back

module udp_ipv4_header_builder import uihb_pkg::*; #(
  parameter int MAX_FRAME = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // src_port, dst_ip, dst_port, payload_len
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // frame_byte
  output logic        m_tlast,
  output logic        m_tuser,   // rejected
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  cfg_t cfg;
  req_t front_req;
  req_t q_data;
  logic q_valid;
  logic q_pop;
  logic push;

  assign cfg_ready = 1'b1;
  assign push      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_mac   <= LOCAL_MAC_RST;
      cfg.peer_mac  <= PEER_MAC_RST;
      cfg.own_ip    <= LOCAL_IP_RST;
      cfg.hop_limit <= HOP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOCAL_MAC: cfg.own_mac   <= cfg_data;
        CFG_PEER_MAC:  cfg.peer_mac  <= cfg_data;
        CFG_LOCAL_IP:  cfg.own_ip    <= cfg_data[31:0];
        CFG_HOP_LIMIT: cfg.hop_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  uihb_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .cfg      (cfg),
    .udp_sport(s_tdata[15:0]),
    .dst_ip   (s_tdata[47:16]),
    .dst_port (s_tdata[63:48]),
    .body_len (s_tdata[79:64]),
    .req      (front_req)
  );

  uihb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(front_req),
    .in_ready (s_tready),
    .pop      (q_pop),
    .out_valid(q_valid),
    .out_data (q_data)
  );

  uihb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_reject(m_tuser)
  );

  a_reject_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("rejection transaction without tlast");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'h00)
    else $error("rejection transaction with nonzero data");

  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a header");

endmodule
